>>> hw/rtl/bcw_pkg.sv
// bcw_pkg: shared types and constants for the bbr congestion-window engine
// used by bcw_divider and bbr_congestion_window_top; no dependencies
package bcw_pkg;

   // event kinds carried in req_tuser
   localparam logic [1:0] EV_INIT = 2'd0;
   localparam logic [1:0] EV_RTT  = 2'd1;
   localparam logic [1:0] EV_ACK  = 2'd2;
   localparam logic [1:0] EV_RTO  = 2'd3;

   // phase codes carried in rsp_tuser
   localparam logic [1:0] PH_STARTUP = 2'd0;
   localparam logic [1:0] PH_DRAIN   = 2'd1;
   localparam logic [1:0] PH_PROBE_BW  = 2'd2;
   localparam logic [1:0] PH_PROBE_RTT = 2'd3;

   // register indexes
   localparam logic [1:0] REG_SEGMENT  = 2'd0;
   localparam logic [1:0] REG_INIT_WIN = 2'd1;
   localparam logic [1:0] REG_FILTER   = 2'd2;
   localparam logic [1:0] REG_PROBE    = 2'd3;

   localparam logic [13:0] SEGMENT_RESET  = 14'd1460;
   localparam logic [15:0] INIT_WIN_RESET = 16'd4380;
   localparam logic [30:0] FILTER_RESET   = 31'd10000;
   localparam logic [30:0] PROBE_RESET    = 31'd200;

   localparam logic [11:0] STARTUP_GAIN = 12'd2885;   // 2885/1024, about 2.817, in q10
   localparam logic [15:0] WIN_MAX      = 16'hFFFF;
   localparam int          DIV_STEPS    = 48;

   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [47:0] quotient;
   } div_sts_type;

   // probe-bandwidth gain cycle, q10
   function automatic logic [10:0] gain_q10(input logic [2:0] idx);
      logic [10:0] g;
      case (idx)
         3'd3, 3'd6: g = 11'd1280;
         default:    g = 11'd1024;
      endcase
      return g;
   endfunction

endpackage

>>> hw/rtl/bbr_congestion_window_top.sv
// bbr_congestion_window_top: bbr v1 congestion-window engine with csr port
// depends on bcw_pkg and bcw_divider
//
//  channel  | direction | transfer contents
//  req_*    | in        | tuser: kind; tdata: time_now, rtt_sample, newly_acked, flight
//  rsp_*    | out       | tuser: phase_out; tdata: window, bandwidth, min_rtt
//  csr_*    | in/out    | apb writes and reads of the four registers
//
// init and rtt events go from the exec state straight to done; timeouts pass
// through the multiply, bdp and post states; an ack that closes a round with a rate
// sample adds the serial 48/32 division (one quotient bit per cycle)
// req_tready is high only while the sequencer is idle; a result waits in
// the output register while the next event is accepted
// synchronous active-high reset loads register defaults and clears state
module bbr_congestion_window_top #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // time_now, rtt_sample, newly_acked, bytes_in_flight
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // window_bytes, bandwidth_estimate, min_rtt_estimate
   output logic [1:0]  rsp_tuser,   // phase_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bcw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_MUL, ST_BDP, ST_POST, ST_ROUND,
      ST_DIV, ST_BW, ST_NEWINT, ST_MULT, ST_APPLY, ST_DONE
   } state_type;

   typedef enum logic [1:0] {CTX_RTO, CTX_DRAIN, CTX_PHASE} ctx_type;

   // configuration registers
   logic [13:0] seg_ff;
   logic [15:0] init_win_ff;
   logic [30:0] filter_ff;
   logic [30:0] probe_ff;

   // engine state
   state_type            state_ff;
   ctx_type              ctx_ff;
   logic [15:0]          window_ff;
   logic [1:0]           phase_ff;
   logic [31:0]          min_rtt_ff;
   logic [TIME_BITS-1:0] rtt_exp_ff;
   logic [31:0]          bw_ff;
   logic [TIME_BITS-1:0] bw_exp_ff;
   logic [31:0]          deliv_ff;
   logic [TIME_BITS-1:0] ib_ff;
   logic [2:0]           gain_idx_ff;
   logic [TIME_BITS-1:0] prb_ff;
   logic [1:0]           rounds_ff;
   logic                 pending_ff;

   // latched event
   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [31:0]          sample_ff;
   logic [15:0]          acked_ff;
   logic [15:0]          flight_ff;
   logic [15:0]          bdp_ff;

   // shared multiplier
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod_ff;

   // result register
   logic        rsp_valid_ff;
   logic [79:0] rsp_data_ff;
   logic [1:0]  rsp_phase_ff;

   div_req_type div_req;
   div_sts_type div_sts;

   logic [15:0]          floor4;
   logic [47:0]          prod_hi;
   logic [15:0]          bdp_calc;
   logic [15:0]          base;
   logic [17:0]          grow;
   logic [17:0]          scaled;
   logic [15:0]          scaled_sat;
   logic [15:0]          cut;
   logic [TIME_BITS-1:0] elapsed;
   logic [31:0]          quo_sat;
   logic [15:0]          half_bdp;
   logic                 csr_wr;

   assign floor4  = {seg_ff, 2'b00};
   assign prod_hi = prod_ff[63:16];
   assign base    = (bdp_ff != 16'd0) ? bdp_ff : floor4;
   assign cut     = {1'b0, flight_ff[15:1]};
   assign elapsed = now_ff - ib_ff;
   assign quo_sat = (div_sts.quotient[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                       : div_sts.quotient[31:0];
   assign half_bdp = {1'b0, bdp_ff[15:1]};
   assign grow    = {2'b00, window_ff} + {5'b0, window_ff[15:3]} + {4'b0, seg_ff};
   assign scaled  = prod_ff[27:10];
   assign scaled_sat = (scaled[17:16] != 2'b00) ? WIN_MAX : scaled[15:0];

   // bandwidth-delay product from the registered product
   always_comb begin
      if (bw_ff == 32'd0 || min_rtt_ff == 32'd0) begin
         bdp_calc = 16'd0;
      end else if (prod_hi < {32'd0, floor4}) begin
         bdp_calc = floor4;
      end else if (prod_hi > {32'd0, WIN_MAX}) begin
         bdp_calc = WIN_MAX;
      end else begin
         bdp_calc = prod_hi[15:0];
      end
   end

   // multiplier operand select
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = bw_ff;
         mul_b = min_rtt_ff;
      end else if (phase_ff == PH_STARTUP) begin
         mul_a = {16'd0, bdp_ff};
         mul_b = {20'd0, STARTUP_GAIN};
      end else begin
         mul_a = {16'd0, base};
         mul_b = {21'd0, gain_q10(gain_idx_ff)};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign div_req.start    = (state_ff == ST_ROUND) && pending_ff && (ib_ff != '0)
                             && (now_ff > ib_ff) && (deliv_ff != 32'd0);
   assign div_req.dividend = {deliv_ff, 16'd0};
   assign div_req.divisor  = 32'(elapsed);

   bcw_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SEGMENT:  csr_prdata = {18'd0, seg_ff};
         REG_INIT_WIN: csr_prdata = {16'd0, init_win_ff};
         REG_FILTER:   csr_prdata = {1'b0, filter_ff};
         REG_PROBE:    csr_prdata = {1'b0, probe_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff      <= SEGMENT_RESET;
         init_win_ff <= INIT_WIN_RESET;
         filter_ff   <= FILTER_RESET;
         probe_ff    <= PROBE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_SEGMENT:  seg_ff      <= csr_pwdata[13:0];
            REG_INIT_WIN: init_win_ff <= csr_pwdata[15:0];
            REG_FILTER:   filter_ff   <= csr_pwdata[30:0];
            REG_PROBE:    probe_ff    <= csr_pwdata[30:0];
            default:      ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_phase_ff;

   // event sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctx_ff       <= CTX_RTO;
         window_ff    <= INIT_WIN_RESET;
         phase_ff     <= PH_STARTUP;
         min_rtt_ff   <= '0;
         rtt_exp_ff   <= '0;
         bw_ff        <= '0;
         bw_exp_ff    <= '0;
         deliv_ff     <= '0;
         ib_ff        <= '0;
         gain_idx_ff  <= '0;
         prb_ff       <= '0;
         rounds_ff    <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the done state the result register is reloaded instead
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff   <= req_tuser;
                  now_ff    <= TIME_BITS'(req_tdata[31:0]);
                  sample_ff <= req_tdata[63:32];
                  acked_ff  <= req_tdata[79:64];
                  flight_ff <= req_tdata[95:80];
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               unique case (kind_ff)
                  EV_INIT: begin
                     phase_ff    <= PH_STARTUP;
                     gain_idx_ff <= '0;
                     rounds_ff   <= '0;
                     pending_ff  <= 1'b0;
                     min_rtt_ff  <= '0;
                     rtt_exp_ff  <= '0;
                     bw_ff       <= '0;
                     bw_exp_ff   <= '0;
                     deliv_ff    <= '0;
                     ib_ff       <= '0;
                     prb_ff      <= '0;
                     window_ff   <= init_win_ff;
                     state_ff    <= ST_DONE;
                  end
                  EV_RTT: begin
                     if (sample_ff != 32'd0 && (min_rtt_ff == 32'd0
                         || now_ff >= rtt_exp_ff || sample_ff < min_rtt_ff)) begin
                        min_rtt_ff <= sample_ff;
                        rtt_exp_ff <= now_ff + TIME_BITS'(filter_ff);
                     end
                     pending_ff <= 1'b1;
                     state_ff   <= ST_DONE;
                  end
                  EV_ACK: begin
                     deliv_ff <= deliv_ff + {16'd0, acked_ff};
                     if (phase_ff == PH_DRAIN) begin
                        ctx_ff   <= CTX_DRAIN;
                        state_ff <= ST_MUL;
                     end else begin
                        state_ff <= ST_ROUND;
                     end
                  end
                  default: begin
                     ctx_ff   <= CTX_RTO;
                     state_ff <= ST_MUL;
                  end
               endcase
            end
            ST_MUL: begin
               state_ff <= ST_BDP;
            end
            ST_BDP: begin
               bdp_ff   <= bdp_calc;
               state_ff <= ST_POST;
            end
            ST_POST: begin
               unique case (ctx_ff)
                  CTX_RTO: begin
                     if (min_rtt_ff != 32'd0 && now_ff < rtt_exp_ff) begin
                        window_ff <= (half_bdp < floor4) ? floor4 : half_bdp;
                     end else begin
                        window_ff <= {2'b00, seg_ff};
                     end
                     if (phase_ff == PH_STARTUP || phase_ff == PH_DRAIN) begin
                        phase_ff <= (min_rtt_ff != 32'd0) ? PH_PROBE_BW : PH_STARTUP;
                     end
                     state_ff <= ST_DONE;
                  end
                  CTX_DRAIN: begin
                     if (bdp_ff != 16'd0 && flight_ff <= bdp_ff) begin
                        phase_ff <= PH_PROBE_BW;
                        state_ff <= ST_DONE;
                     end else begin
                        if (flight_ff >= {1'b0, window_ff[15:1]} && window_ff > bdp_ff) begin
                           if (window_ff > cut && (window_ff - cut) >= bdp_ff) begin
                              window_ff <= window_ff - cut;
                           end else begin
                              window_ff <= bdp_ff;
                           end
                        end
                        state_ff <= ST_ROUND;
                     end
                  end
                  default: begin
                     unique case (phase_ff)
                        PH_STARTUP: begin
                           if (bw_ff == 32'd0 || min_rtt_ff == 32'd0) begin
                              window_ff <= (grow[17:16] != 2'b00) ? WIN_MAX : grow[15:0];
                              state_ff  <= ST_DONE;
                           end else begin
                              state_ff <= ST_MULT;
                           end
                        end
                        PH_PROBE_BW: begin
                           if (now_ff >= rtt_exp_ff) begin
                              phase_ff  <= PH_PROBE_RTT;
                              prb_ff    <= now_ff;
                              window_ff <= ({2'b00, bdp_ff[15:2]} < floor4) ? floor4
                                           : {2'b00, bdp_ff[15:2]};
                              state_ff  <= ST_DONE;
                           end else begin
                              state_ff <= ST_MULT;
                           end
                        end
                        PH_PROBE_RTT: begin
                           if (now_ff >= TIME_BITS'(prb_ff + TIME_BITS'(probe_ff))) begin
                              phase_ff <= PH_PROBE_BW;
                           end
                           state_ff <= ST_DONE;
                        end
                        default: begin
                           state_ff <= ST_DONE;
                        end
                     endcase
                  end
               endcase
            end
            ST_ROUND: begin
               if (!pending_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  pending_ff <= 1'b0;
                  state_ff   <= div_req.start ? ST_DIV : ST_NEWINT;
               end
            end
            ST_DIV: begin
               if (div_sts.done) begin
                  state_ff <= ST_BW;
               end
            end
            ST_BW: begin
               if (now_ff >= bw_exp_ff || quo_sat > bw_ff) begin
                  bw_ff     <= quo_sat;
                  bw_exp_ff <= now_ff + TIME_BITS'(filter_ff);
               end
               state_ff <= ST_NEWINT;
            end
            ST_NEWINT: begin
               deliv_ff <= '0;
               ib_ff    <= now_ff;
               ctx_ff   <= CTX_PHASE;
               state_ff <= ST_MUL;
            end
            ST_MULT: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (phase_ff == PH_STARTUP) begin
                  if (scaled_sat > window_ff) begin
                     window_ff <= scaled_sat;
                  end
                  if (rounds_ff != 2'd0) begin
                     phase_ff <= PH_DRAIN;
                  end
                  if (rounds_ff != 2'd2) begin
                     rounds_ff <= rounds_ff + 2'd1;
                  end
               end else begin
                  window_ff   <= (scaled_sat < floor4) ? floor4 : scaled_sat;
                  gain_idx_ff <= gain_idx_ff + 3'd1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {min_rtt_ff, bw_ff, window_ff};
                  rsp_phase_ff <= phase_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a result appears only when the sequencer finishes an event
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   // an accepted event always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("event transfer not executed");

   // startup round counter saturates at two
   assert property (@(posedge clock) disable iff (reset)
      rounds_ff != 2'd3)
      else $error("round counter overflow");

   // the divider only runs while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside wait state");

endmodule

>>> hw/rtl/bcw_divider.sv
// bcw_divider: restoring 48 by 32 bit divider, one quotient bit per cycle
// depends on bcw_pkg
module bcw_divider (
   input  logic                clock,
   input  logic                reset,
   input  bcw_pkg::div_req_type req,
   output bcw_pkg::div_sts_type sts
);
   import bcw_pkg::*;

   logic [31:0] rem_ff;
   logic [47:0] quo_ff;
   logic [31:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, quo_ff[47]};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'(DIV_STEPS - 1));
         if (req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= req.dividend;
            div_ff  <= req.divisor;
         end else if (busy_ff) begin
            if (!diff[32]) begin
               rem_ff <= diff[31:0];
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for bbr_congestion_window_top, with a predictor of
// the bbr v1 window engine in a scoreboard class; depends on bcw_pkg and the rtl
module tb;
   import bcw_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] now;
      logic [31:0] rtt;
      logic [15:0] acked;
      logic [15:0] flight;
   } cw_event_type;

   typedef struct {
      logic [15:0] window;
      logic [1:0]  phase;
      logic [31:0] bw;
      logic [31:0] min_rtt;
   } cw_result_type;

   // predictor of the window engine plus the queue of expected results
   class cwnd_scoreboard;
      bit [13:0] seg_size;
      bit [15:0] init_win;
      bit [30:0] filt_win;
      bit [30:0] probe_time;
      bit [31:0] win, min_rtt, rtt_expiry, bw, bw_expiry, delivered, intv_begin;
      bit [31:0] prt_begin;
      bit [1:0]  phase, startup_rounds;
      bit [2:0]  gain_idx;
      bit        round_open;
      cw_result_type expected_q[$];
      int        mismatches;

      function void clear_flow();
         phase = PH_STARTUP; gain_idx = 0; startup_rounds = 0; round_open = 0;
         min_rtt = 0; rtt_expiry = 0; bw = 0; bw_expiry = 0;
         delivered = 0; intv_begin = 0; prt_begin = 0;
         win = {16'd0, init_win};
      endfunction

      function void power_up();
         seg_size = SEGMENT_RESET; init_win = INIT_WIN_RESET;
         filt_win = FILTER_RESET; probe_time = PROBE_RESET;
         mismatches = 0;
         clear_flow();
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_SEGMENT:  seg_size = val[13:0];
            REG_INIT_WIN: init_win = val[15:0];
            REG_FILTER:   filt_win = val[30:0];
            REG_PROBE:    probe_time = val[30:0];
         endcase
      endfunction

      function bit [31:0] floor4();
         return {18'd0, seg_size} * 4;
      endfunction

      // bandwidth-delay product, floored at four segments and capped at 16 bits
      function bit [31:0] bdp_bytes();
         bit [63:0] p;
         if (bw == 0 || min_rtt == 0) return 0;
         p = ({32'd0, bw} * {32'd0, min_rtt}) >> 16;
         if (p < floor4()) p = floor4();
         if (p > 65535) p = 65535;
         return p[31:0];
      endfunction

      function bit [31:0] gain_of(bit [2:0] i);
         return (i == 3 || i == 6) ? 32'd1280 : 32'd1024;
      endfunction

      function void ack_update(bit [31:0] now, bit [31:0] acked, bit [31:0] flight);
         bit [31:0] bdp, cut, target, w, base;
         bit [63:0] q;
         delivered = delivered + acked;
         if (phase == PH_DRAIN) begin
            bdp = bdp_bytes();
            if (bdp != 0 && flight <= bdp) begin
               phase = PH_PROBE_BW;
               return;   // drain exit leaves the round pending
            end
            if (flight >= win / 2 && win > bdp) begin
               cut = flight / 2;
               win = (win > cut) ? win - cut : bdp;
               if (win < bdp) win = bdp;
            end
         end
         if (!round_open) return;
         round_open = 0;
         if (intv_begin != 0 && now > intv_begin && delivered != 0) begin
            q = ({32'd0, delivered} << 16) / {32'd0, now - intv_begin};
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            if (now >= bw_expiry || q > bw) begin
               bw = q[31:0];
               bw_expiry = now + filt_win;
            end
         end
         delivered = 0;
         intv_begin = now;
         bdp = bdp_bytes();
         if (phase == PH_STARTUP) begin
            if (bw == 0 || min_rtt == 0) begin
               w = win + win / 8 + {18'd0, seg_size};
               win = (w > 65535) ? 65535 : w;
               return;
            end
            target = (bdp * 2885) >> 10;
            if (target > 65535) target = 65535;
            if (target > win) win = target;
            if (startup_rounds < 2) startup_rounds++;
            if (startup_rounds >= 2 && target <= win) phase = PH_DRAIN;
         end else if (phase == PH_PROBE_BW) begin
            if (now >= rtt_expiry) begin
               phase = PH_PROBE_RTT;
               prt_begin = now;
               win = bdp / 4;
               if (win < floor4()) win = floor4();
            end else begin
               base = (bdp != 0) ? bdp : floor4();
               w = (base * gain_of(gain_idx)) >> 10;
               if (w < floor4()) w = floor4();
               if (w > 65535) w = 65535;
               win = w;
               gain_idx = gain_idx + 3'd1;
            end
         end else if (phase == PH_PROBE_RTT) begin
            if (now >= prt_begin + probe_time) phase = PH_PROBE_BW;
         end
      endfunction

      // an event transfer was accepted: advance the model and queue its result
      function void note_event(cw_event_type ev);
         cw_result_type r;
         bit [31:0] bdp;
         case (ev.kind)
            EV_INIT: clear_flow();
            EV_RTT: begin
               if (ev.rtt != 0 && (min_rtt == 0 || ev.now >= rtt_expiry ||
                                   ev.rtt < min_rtt)) begin
                  min_rtt = ev.rtt;
                  rtt_expiry = ev.now + filt_win;
               end
               round_open = 1;
            end
            EV_ACK: ack_update(ev.now, {16'd0, ev.acked}, {16'd0, ev.flight});
            default: begin
               bdp = bdp_bytes();
               if (min_rtt != 0 && ev.now < rtt_expiry) begin
                  win = bdp / 2;
                  if (win < floor4()) win = floor4();
               end else begin
                  win = {18'd0, seg_size};
               end
               if (phase == PH_STARTUP || phase == PH_DRAIN)
                  phase = (min_rtt != 0) ? PH_PROBE_BW : PH_STARTUP;
            end
         endcase
         r.window = win[15:0]; r.phase = phase; r.bw = bw; r.min_rtt = min_rtt;
         expected_q.push_back(r);
      endfunction

      function void check_result(cw_result_type got);
         cw_result_type exp_r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer w=%0d ph=%0d",
                                           got.window, got.phase);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.window !== exp_r.window || got.phase !== exp_r.phase ||
             got.bw !== exp_r.bw || got.min_rtt !== exp_r.min_rtt) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp w=%0d ph=%0d bw=%0h rtt=%0d",
                         " got w=%0d ph=%0d bw=%0h rtt=%0d"},
                        exp_r.window, exp_r.phase, exp_r.bw, exp_r.min_rtt,
                        got.window, got.phase, got.bw, got.min_rtt);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // time_now, rtt_sample, newly_acked, bytes_in_flight
   logic [1:0]  req_tuser = EV_INIT;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;   // window_bytes, bandwidth_estimate, min_rtt_estimate
   logic [1:0]  rsp_tuser;   // phase_out
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cwnd_scoreboard sb;
   bit   quiet;           // sender runs without gaps while set
   int   results_seen;
   bit [31:0] clk_now;    // running timestamp for well-formed event sequences

   bbr_congestion_window_top i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // hard limit on the run
   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // one event transfer; the valid stays high across back-to-back transfers
   task automatic send_event(input cw_event_type ev);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= ev.kind;
      req_tdata  <= {ev.flight, ev.acked, ev.rtt, ev.now};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sb.note_event(ev);
   endtask

   task automatic send(input logic [1:0] k, input logic [31:0] t, input logic [31:0] r,
                       input logic [15:0] a, input logic [15:0] f);
      cw_event_type ev;
      ev.kind = k; ev.now = t; ev.rtt = r; ev.acked = a; ev.flight = f;
      send_event(ev);
   endtask

   // apb write: setup cycle then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.write_reg(idx, val);
   endtask

   // block goes idle: every expected result back, then some settling cycles
   task automatic drain_block();
      req_tvalid <= 0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // well-formed flow: init then rtt samples and acks with advancing time;
   // a share of timeouts, re-inits and fully random noise transfers
   task automatic random_flow(input int n);
      int pick;
      cw_event_type ev;
      clk_now = $urandom_range(1, 1000);
      send(EV_INIT, clk_now, 0, 0, 0);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (i % 40 == 39) quiet = !quiet;
         clk_now = clk_now + $urandom_range(1, 40);
         if (pick < 30)
            send(EV_RTT, clk_now, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(10, 200),
                 16'($urandom), 16'($urandom));
         else if (pick < 84)
            send(EV_ACK, clk_now, $urandom, 16'($urandom_range(200, 4000)),
                 16'($urandom_range(0, 30000)));
         else if (pick < 88)
            send(EV_RTO, clk_now, $urandom, 16'($urandom), 16'($urandom));
         else if (pick < 90)
            send(EV_INIT, clk_now, $urandom, 16'($urandom), 16'($urandom));
         else begin
            ev.kind = 2'($urandom); ev.now = $urandom; ev.rtt = $urandom;
            ev.acked = 16'($urandom); ev.flight = 16'($urandom);
            send_event(ev);
         end
      end
   endtask

   // result side: random stalls, plus one long hold so the block backs up
   initial begin
      cw_result_type got;
      int stall;
      results_seen = 0;
      @(negedge reset);
      forever begin
         stall = (results_seen == 300) ? 600 : (quiet ? 0 : $urandom_range(0, 18));
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(negedge clock); while (!rsp_tvalid);
         got.window  = rsp_tdata[15:0];
         got.bw      = rsp_tdata[47:16];
         got.min_rtt = rsp_tdata[79:48];
         got.phase   = rsp_tuser;
         @(posedge clock);
         sb.check_result(got);
         results_seen++;
      end
   end

   initial begin
      int wait_cycles;
      sb = new();
      sb.power_up();
      quiet = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, each kind, zero rtt sample, rate overflow,
      // unset interval, drain and timeout handling
      send(EV_RTT, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
      send(EV_ACK, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
      send(EV_RTT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      send(EV_RTO, 32'hFFFF_FFFF, 0, 0, 0);
      send(EV_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send(EV_RTT, 32'd1, 32'd1, 0, 0);
      send(EV_ACK, 32'd1, 0, 16'hFFFF, 0);
      send(EV_ACK, 32'd1, 0, 16'hFFFF, 0);
      send(EV_ACK, 32'd1, 0, 16'hFFFF, 0);
      send(EV_RTT, 32'd2, 32'd5, 0, 0);
      send(EV_ACK, 32'd2, 0, 16'hFFFF, 16'hFFFF);
      send(EV_RTO, 32'd3, 0, 0, 16'hFFFF);
      send(EV_INIT, 32'd10, 0, 0, 0);
      send(EV_RTT, 32'd10, 32'd100, 0, 0);
      send(EV_ACK, 32'd20, 0, 3000, 1000);
      for (int i = 0; i < 4; i++) begin
         send(EV_RTT, 32'd30 + 10 * i, 32'd100, 0, 0);
         send(EV_ACK, 32'd35 + 10 * i, 0, 16'd20000, 16'd60000);
      end
      send(EV_ACK, 32'd80, 0, 16'd100, 16'd0);
      send(EV_RTO, 32'd90, 0, 0, 0);

      // register settings, extremes included, each between idle points
      for (int ph = 0; ph < 5; ph++) begin
         drain_block();
         case (ph)
            1: begin
               csr_write(REG_SEGMENT, 32'd1);   csr_write(REG_INIT_WIN, 32'd1);
               csr_write(REG_FILTER, 32'd1);    csr_write(REG_PROBE, 32'd1);
            end
            2: begin
               csr_write(REG_SEGMENT, 32'd16383); csr_write(REG_INIT_WIN, 32'd65535);
               csr_write(REG_FILTER, 32'h7FFF_FFFF); csr_write(REG_PROBE, 32'h7FFF_FFFF);
            end
            3: begin
               csr_write(REG_SEGMENT, 32'd536);  csr_write(REG_INIT_WIN, 32'd10000);
               csr_write(REG_FILTER, 32'd300);   csr_write(REG_PROBE, 32'd50);
            end
            4: begin
               csr_write(REG_SEGMENT, 32'd1460); csr_write(REG_INIT_WIN, 32'd4380);
               csr_write(REG_FILTER, 32'd800);   csr_write(REG_PROBE, 32'd120);
            end
            default: ;
         endcase
         for (int f = 0; f < 4; f++) random_flow(64);
      end

      // wait out outstanding results, bounded
      req_tvalid <= 0;
      wait_cycles = 0;
      while (sb.expected_q.size() > 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/bcw_pkg.sv
hw/rtl/bcw_divider.sv
hw/rtl/bbr_congestion_window_top.sv
tb/sv/tb.sv
